FILE: rtl/assert_macros.svh
// shared assertion helpers for the oscillator bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/posb_pkg.sv
package posb_pkg;

    // default configuration
    localparam int DEF_VOICES         = 60;
    localparam int DEF_TABLE_BITS     = 10;
    localparam int DEF_SINE_AMPLITUDE = 2047;

    // field widths
    localparam int REQ_W    = 2;
    localparam int KEY_W    = 6;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 12;
    localparam int ROM_W    = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ATTACK  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_RELEASE = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = REQ_W'(2);

    // output saturation limits
    localparam int SAMPLE_MAX     = 2047;
    localparam int SAMPLE_MIN     = -2048;
    localparam int SAMPLE_MIN_MAG = 2048;

    // pi/2 in q30 and the taylor denominators (2k)(2k+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 10;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // voice store control between sequencer and store
    typedef struct packed {
        logic attack;
        logic rd;
        logic upd;
    } t_store_ctl;

    // one sine table entry, quarter-wave symmetric, evaluated at elaboration
    function automatic logic signed [ROM_W-1:0] sine_entry(
        input int unsigned idx,
        input int unsigned table_bits,
        input int unsigned amp
    );
        logic [63:0]              quarter;
        logic [63:0]              quad;
        logic [63:0]              rem;
        logic [63:0]              r;
        logic [63:0]              x;
        logic [63:0]              term;
        logic signed [63:0]       sum;
        logic [63:0]              scaled;
        logic signed [ROM_W-1:0]  v;
        quarter = 64'd1 << (table_bits - 2);
        quad    = 64'(idx) >> (table_bits - 2);
        rem     = 64'(idx) & (quarter - 64'd1);
        r       = quad[0] ? (quarter - rem) : rem;
        x       = (r * HALF_PI_Q30) >> (table_bits - 2);
        term    = x;
        sum     = signed'(x);
        for (int k = 0; k < TAYLOR_TERMS; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k % 2 == 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        scaled = ((unsigned'(sum) * 64'(amp)) + (64'd1 << 29)) >> 30;
        v      = ROM_W'(scaled);
        if (quad[1]) begin
            v = -v;
        end
        return v;
    endfunction

endpackage

FILE: rtl/posb_sine_rom.sv
module posb_sine_rom #(
    parameter int TABLE_BITS     = posb_pkg::DEF_TABLE_BITS,
    parameter int SINE_AMPLITUDE = posb_pkg::DEF_SINE_AMPLITUDE
) (
    input  logic                                i_clk,
    input  logic [TABLE_BITS-1:0]               i_addr,
    output logic signed [posb_pkg::ROM_W-1:0]   o_data
);
    import posb_pkg::*;

    localparam int ROM_SIZE = 1 << TABLE_BITS;

    logic signed [ROM_W-1:0] w_rom [ROM_SIZE];
    logic signed [ROM_W-1:0] r_data;

    // constant table built entry by entry
    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam logic signed [ROM_W-1:0] ENTRY = sine_entry(g, TABLE_BITS, SINE_AMPLITUDE);
        assign w_rom[g] = ENTRY;
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: rtl/posb_voice_store.sv
module posb_voice_store #(
    parameter  int VOICES = posb_pkg::DEF_VOICES,
    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                          i_clk,
    input  posb_pkg::t_store_ctl          i_ctl,
    input  logic [VIDX_W-1:0]             i_wr_addr,
    input  logic [posb_pkg::PHASE_W-1:0]  i_step,
    input  logic [VIDX_W-1:0]             i_rd_addr,
    output logic [posb_pkg::PHASE_W-1:0]  o_phase
);
    import posb_pkg::*;

    logic [PHASE_W-1:0] mem_phase [VOICES];
    logic [PHASE_W-1:0] mem_step  [VOICES];

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_step;
    logic [VIDX_W-1:0]  r_rd_addr;

    logic               w_wr_en;
    logic [VIDX_W-1:0]  w_wr_addr;
    logic [PHASE_W-1:0] w_wr_phase;

    // single phase write port: attack clears, walk writes the advanced phase
    always_comb begin
        w_wr_en    = i_ctl.attack | i_ctl.upd;
        w_wr_addr  = i_ctl.attack ? i_wr_addr : r_rd_addr;
        w_wr_phase = i_ctl.attack ? '0 : (r_phase + r_step);
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_phase[w_wr_addr] <= w_wr_phase;
        end
        if (i_ctl.attack) begin
            mem_step[i_wr_addr] <= i_step;
        end
        if (i_ctl.rd) begin
            r_phase   <= mem_phase[i_rd_addr];
            r_step    <= mem_step[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    assign o_phase = r_phase;

endmodule

FILE: rtl/posb_scale.sv
module posb_scale #(
    parameter int SUM_W = 23
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [SUM_W-1:0]               i_sum,
    output logic                                  o_done,
    output logic signed [posb_pkg::SAMPLE_W-1:0]  o_sample
);
    import posb_pkg::*;

    // divide by 5 as multiply by ceil(2^k/5), exact for magnitudes below 2^(k-2)
    localparam int MAG_W  = (SUM_W > 14) ? SUM_W : 14;
    localparam int DIV_K  = MAG_W + 3;
    localparam int M_W    = MAG_W + 1;
    localparam int PROD_W = MAG_W + M_W;
    localparam int Q_W    = PROD_W - DIV_K;
    localparam logic [M_W-1:0] DIV_M = M_W'(((64'd1 << DIV_K) + 64'd4) / 64'd5);

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_done;
    logic                       r_neg1;
    logic                       r_neg2;
    logic [MAG_W-1:0]           r_mag;
    logic [PROD_W-1:0]          r_prod;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic signed [MAG_W-1:0]    w_ext;
    logic [Q_W-1:0]             w_q;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_ext = MAG_W'(i_sum);
    assign w_q   = r_prod[PROD_W-1:DIV_K];

    // restore sign and clip
    always_comb begin
        if (r_neg2) begin
            w_sat = (w_q > Q_W'(SAMPLE_MIN_MAG)) ? SAMPLE_W'(SAMPLE_MIN)
                                                 : -signed'(w_q[SAMPLE_W-1:0]);
        end else begin
            w_sat = (w_q > Q_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                             : signed'(w_q[SAMPLE_W-1:0]);
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    // magnitude, product, clipped result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg1 <= w_ext[MAG_W-1];
            r_mag  <= w_ext[MAG_W-1] ? unsigned'(-w_ext) : unsigned'(w_ext);
        end
        if (r_v1) begin
            r_neg2 <= r_neg1;
            r_prod <= r_mag * DIV_M;
        end
        if (r_v2) begin
            r_sample <= w_sat;
        end
    end

    assign o_done   = r_done;
    assign o_sample = r_sample;

endmodule

FILE: rtl/polyphonic_sine_oscillator_bank.sv
// Polyphonic sine oscillator bank, one phase accumulator per key.
// Input channel: i_valid / o_stall with i_req_type, i_key, i_phase_step.
//   attack (key in range): key goes active, phase cleared, step stored.
//   release (key in range): key goes inactive. Other codes are dropped.
//   Attack, release and unused codes give no output beat.
// A sample request walks every voice through one shared path: voice store
//   read, phase advance, sine ROM read, accumulate. One voice per cycle.
// The sum is divided by 5 (toward zero) and clipped to 12 bits.
// Output channel: o_valid / i_stall with o_sample, one beat per sample request.
// A sample request runs from acceptance to o_valid through the walk over
//   the voice store memory, then the ROM read, divide and output stages.
// A new sample request is taken only once the last result is loaded into
//   the output register; attack and release beats are taken one per
//   cycle while o_stall is low.
// o_stall is high from acceptance of a request until its result is loaded
//   into the output register. A finished sample waits there while i_stall
//   is high, and a further request holds its result until the slot frees.
// Reset (synchronous, i_rst_n low) clears all active keys and the handshake
//   state; phases and steps are written by attack before they are used.
module polyphonic_sine_oscillator_bank #(
    parameter int VOICES         = posb_pkg::DEF_VOICES,
    parameter int TABLE_BITS     = posb_pkg::DEF_TABLE_BITS,
    parameter int SINE_AMPLITUDE = posb_pkg::DEF_SINE_AMPLITUDE
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [posb_pkg::REQ_W-1:0]             i_req_type,
    input  logic [posb_pkg::KEY_W-1:0]             i_key,
    input  logic [posb_pkg::PHASE_W-1:0]           i_phase_step,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [posb_pkg::SAMPLE_W-1:0]   o_sample
);
    import posb_pkg::*;

`include "assert_macros.svh"

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W  = $clog2(VOICES * SINE_AMPLITUDE + 1) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [VOICES-1:0]          r_active;
    logic [VIDX_W-1:0]          r_idx;
    logic                       r_p1_v;
    logic                       r_p1_act;
    logic                       r_p2_v;
    logic                       r_p2_act;
    logic signed [SUM_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    logic                       w_in_acc;
    logic                       w_key_ok;
    logic [VIDX_W-1:0]          w_key_idx;
    logic                       w_req_sample;
    logic                       w_last;
    logic                       w_scl_start;
    logic                       w_scl_done;
    logic signed [SAMPLE_W-1:0] w_scl_sample;
    logic                       w_out_load;
    logic [PHASE_W-1:0]         w_phase;
    logic signed [ROM_W-1:0]    w_rom_data;
    t_store_ctl                 w_ctl;

    // input beat decode
    assign w_in_acc     = i_valid && !o_stall;
    assign w_key_ok     = int'(i_key) < VOICES;
    assign w_key_idx    = VIDX_W'(i_key);
    assign w_req_sample = w_in_acc && (i_req_type == REQ_SAMPLE);
    assign w_last       = (r_idx == VIDX_W'(VOICES - 1));
    assign w_scl_start  = (r_state == ST_DRAIN) && !r_p1_v && !r_p2_v;
    assign w_out_load   = (r_state == ST_PUSH) && (!r_out_valid || !i_stall);

    // voice store control
    assign w_ctl.attack = w_in_acc && (i_req_type == REQ_ATTACK) && w_key_ok;
    assign w_ctl.rd     = (r_state == ST_WALK);
    assign w_ctl.upd    = r_p1_v && r_p1_act;

    posb_voice_store #(
        .VOICES (VOICES)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (w_key_idx),
        .i_step    (i_phase_step),
        .i_rd_addr (r_idx),
        .o_phase   (w_phase)
    );

    posb_sine_rom #(
        .TABLE_BITS     (TABLE_BITS),
        .SINE_AMPLITUDE (SINE_AMPLITUDE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_phase[PHASE_W-1 -: TABLE_BITS]),
        .o_data (w_rom_data)
    );

    posb_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scl_start),
        .i_sum    (r_acc),
        .o_done   (w_scl_done),
        .o_sample (w_scl_sample)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_sample) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_scl_start) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (w_scl_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1_v  <= (r_state == ST_WALK);
            r_p2_v  <= r_p1_v;
            if (w_in_acc && w_key_ok && (i_req_type == REQ_ATTACK)) begin
                r_active[w_key_idx] <= 1'b1;
            end else if (w_in_acc && w_key_ok && (i_req_type == REQ_RELEASE)) begin
                r_active[w_key_idx] <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // voice walk and accumulation
    always_ff @(posedge i_clk) begin
        if (w_req_sample) begin
            r_idx <= '0;
        end else if ((r_state == ST_WALK) && !w_last) begin
            r_idx <= r_idx + VIDX_W'(1);
        end
        r_p1_act <= r_active[r_idx];
        r_p2_act <= r_p1_act;
        if (w_req_sample) begin
            r_acc <= '0;
        end else if (r_p2_v && r_p2_act) begin
            r_acc <= r_acc + SUM_W'(w_rom_data);
        end
        if (w_out_load) begin
            r_out_sample <= w_scl_sample;
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    // checks on the sequencer
    `ASSERT_NEXT(a_req_starts_walk, i_clk, i_rst_n, w_req_sample, (r_state == ST_WALK) && (r_idx == '0), "sample request did not start the voice walk")
    `ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_state == ST_WALK, int'(r_idx) < VOICES, "voice index beyond last voice")
    `ASSERT_IMPL(a_pipe_empty_push, i_clk, i_rst_n, r_state == ST_PUSH, !r_p1_v && !r_p2_v, "walk pipeline busy at output")
    `ASSERT_IMPL(a_done_in_scale, i_clk, i_rst_n, w_scl_done, r_state == ST_SCALE, "scaler finished outside scale phase")

endmodule

FILE: bench/posb_sample_checker.sv
module posb_sample_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic [posb_pkg::REQ_W-1:0]            i_req_type,
    input  logic [posb_pkg::KEY_W-1:0]            i_key,
    input  logic [posb_pkg::PHASE_W-1:0]          i_phase_step,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [posb_pkg::SAMPLE_W-1:0]  i_sample,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import posb_pkg::*;

    localparam int VOICES      = DEF_VOICES;
    localparam int TBL_SIZE    = 1 << DEF_TABLE_BITS;
    localparam int QUARTER     = TBL_SIZE / 4;
    localparam int PHASE_SHIFT = PHASE_W - DEF_TABLE_BITS;
    localparam int MIX_DIVISOR = 5;

    // sine table and per-key oscillator state
    int                        wave_rom [TBL_SIZE];
    bit                        key_on [VOICES];
    bit [PHASE_W-1:0]          key_phase_acc [VOICES];
    bit [PHASE_W-1:0]          key_inc [VOICES];
    logic signed [SAMPLE_W-1:0] sample_queue [$];

    // one quarter-wave point: q30 taylor series of sin, scaled and rounded
    function automatic int quarter_wave(input int unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        x    = (longint'(r) * HALF_PI_Q30) / longint'(QUARTER);
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return int'((longint'(acc) * longint'(DEF_SINE_AMPLITUDE) + (64'd1 << 29)) >> 30);
    endfunction

    // sum active keys, advance their phases, scale by 1/5 and clip to 12 bits
    function automatic logic signed [SAMPLE_W-1:0] mix_next_sample();
        int acc;
        int scaled;
        acc = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (key_on[v]) begin
                acc += wave_rom[key_phase_acc[v] >> PHASE_SHIFT];
                key_phase_acc[v] += key_inc[v];
            end
        end
        scaled = acc / MIX_DIVISOR;
        if (scaled > SAMPLE_MAX) begin
            scaled = SAMPLE_MAX;
        end else if (scaled < SAMPLE_MIN) begin
            scaled = SAMPLE_MIN;
        end
        return SAMPLE_W'(scaled);
    endfunction

    // build the table with quarter-wave symmetry
    initial begin
        int quad;
        int rem;
        int v;
        for (int i = 0; i < TBL_SIZE; i++) begin
            quad = i / QUARTER;
            rem  = i % QUARTER;
            v    = (quad % 2 == 1) ? quarter_wave(QUARTER - rem) : quarter_wave(rem);
            wave_rom[i] = (quad >= 2) ? -v : v;
        end
    end

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                key_on[v] = 1'b0;
            end
            sample_queue.delete();
            o_fail_count = 0;
        end else begin
            // output beat against the oldest expected sample
            if (i_out_valid && !i_out_stall) begin
                if (sample_queue.size() == 0) begin
                    $error("o_sample: no beat expected, actual %0d", i_sample);
                    o_fail_count++;
                end else begin
                    want = sample_queue.pop_front();
                    if (i_sample !== want) begin
                        $error("o_sample: expected %0d, actual %0d", want, i_sample);
                        o_fail_count++;
                    end
                end
            end
            // input beat updates the key state or asks for a sample
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_ATTACK: begin
                        if (i_key < VOICES) begin
                            key_on[i_key]        = 1'b1;
                            key_phase_acc[i_key] = '0;
                            key_inc[i_key]       = i_phase_step;
                        end
                    end
                    REQ_RELEASE: begin
                        if (i_key < VOICES) begin
                            key_on[i_key] = 1'b0;
                        end
                    end
                    REQ_SAMPLE: begin
                        sample_queue.push_back(mix_next_sample());
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = sample_queue.size();
    end

endmodule

FILE: bench/polyphonic_sine_oscillator_bank_tb.sv
module polyphonic_sine_oscillator_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import posb_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
    localparam int VOICES       = DEF_VOICES;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 1000;
    localparam int PAUSE_AT     = 1200;
    localparam int DRAIN_CYCLES = VOICES + 20;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [REQ_W-1:0]           i_req_type;
    logic [KEY_W-1:0]           i_key;
    logic [PHASE_W-1:0]         i_phase_step;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_sample;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int cycle_count = 0;
    bit hold_done   = 1'b0;

    polyphonic_sine_oscillator_bank dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_phase_step (i_phase_step),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample)
    );

    posb_sample_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_phase_step (i_phase_step),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_sample     (o_sample),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    // drive one request beat at the falling edge and wait for acceptance
    task automatic send_beat(
        input logic [REQ_W-1:0]   kind,
        input logic [KEY_W-1:0]   which,
        input logic [PHASE_W-1:0] step,
        input int                 gap
    );
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_req_type   = kind;
        i_key        = which;
        i_phase_step = step;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // sample receiver: random stalls, one long hold while requests keep coming
    initial begin
        int quiet;
        int hold;
        i_stall = 1'b0;
        forever begin
            if (!hold_done && beats_sent >= HOLD_AFTER) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 8);
                hold  = pick_gap();
                i_stall = 1'b0;
                repeat (quiet) @(negedge i_clk);
                if (hold > 0) begin
                    i_stall = 1'b1;
                    repeat (hold) @(negedge i_clk);
                end
            end
        end
    end

    // request stream and verdict
    initial begin
        int                 w_att;
        int                 w_rel;
        int                 w_smp;
        int                 w_bad;
        int                 roll;
        bit                 gappy;
        logic [REQ_W-1:0]   kind;
        logic [KEY_W-1:0]   which;
        logic [PHASE_W-1:0] step;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = REQ_ATTACK;
        i_key        = '0;
        i_phase_step = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // silence, ignored keys and codes, idle release
        send_beat(REQ_SAMPLE, '0, '0, 0);
        send_beat(REQ_ATTACK, KEY_W'(0), QUARTER_TURN, 0);
        send_beat(REQ_ATTACK, KEY_W'(VOICES - 1), QUARTER_TURN, 0);
        send_beat(REQ_ATTACK, KEY_W'(VOICES), 32'hFFFF_FFFF, 0);
        send_beat(REQ_RELEASE, KEY_W'(63), '0, 0);
        send_beat(REQ_RELEASE, KEY_W'(30), '0, 0);
        send_beat(REQ_UNUSED, KEY_W'(1), 32'hFFFF_FFFF, 0);
        for (int k = 1; k <= 4; k++) begin
            send_beat(REQ_ATTACK, KEY_W'(k), QUARTER_TURN, 0);
        end
        // six keys in step: zero, positive clip, zero, negative clip
        repeat (4) send_beat(REQ_SAMPLE, '0, '0, 0);
        // restart, release, zero step, release carrying a step
        send_beat(REQ_ATTACK, KEY_W'(0), 32'hFFFF_FFFF, 0);
        send_beat(REQ_RELEASE, KEY_W'(VOICES - 1), '0, 0);
        send_beat(REQ_SAMPLE, '0, 32'h5555_5555, 0);
        send_beat(REQ_SAMPLE, '0, '0, 1);
        send_beat(REQ_ATTACK, KEY_W'(2), '0, 0);
        send_beat(REQ_RELEASE, KEY_W'(0), 32'hAAAA_AAAA, 0);
        send_beat(REQ_SAMPLE, '0, '0, 0);
        send_beat(REQ_SAMPLE, '0, '0, 2);

        // random segments with varying request mix and idling
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                w_att = $urandom_range(10, 50);
                w_rel = $urandom_range(5, 40);
                w_smp = $urandom_range(20, 60);
                w_bad = $urandom_range(0, 4);
                gappy = ($urandom_range(0, 3) != 0);
            end
            // let the bank drain completely once
            if (n == PAUSE_AT) begin
                i_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            roll = $urandom_range(0, w_att + w_rel + w_smp + w_bad - 1);
            if (roll < w_att) begin
                kind = REQ_ATTACK;
            end else if (roll < w_att + w_rel) begin
                kind = REQ_RELEASE;
            end else if (roll < w_att + w_rel + w_smp) begin
                kind = REQ_SAMPLE;
            end else begin
                kind = REQ_UNUSED;
            end
            which = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(VOICES, 63))
                                                : KEY_W'($urandom_range(0, VOICES - 1));
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                step = $urandom;
            end else if (roll < 7) begin
                step = $urandom_range(0, 32'h00FF_FFFF);
            end else if (roll < 9) begin
                step = PHASE_W'($urandom_range(0, 1023)) << 22;
            end else begin
                case ($urandom_range(0, 3))
                    0:       step = '0;
                    1:       step = 32'hFFFF_FFFF;
                    2:       step = 32'h8000_0000;
                    default: step = QUARTER_TURN;
                endcase
            end
            send_beat(kind, which, step, gappy ? pick_gap() : 0);
        end
        i_valid = 1'b0;

        // drain and settle
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
